// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the slot allocator.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising edge, quiet in reset.
`define NSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define NSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/nsa_pkg.sv
// Package of the slot allocator: sizes, codes, controller states and the
// structs passed between the controller and the row of slot cells.
`default_nettype none

package nsa_pkg;

    // Pool size and derived widths.
    localparam int NODES  = 1024;
    localparam int NW     = $clog2(NODES);
    localparam int HW     = NW + 1;
    localparam int CNT_W  = NW;

    // Fixed field widths of the ports.
    localparam int PAR_W  = 11;
    localparam int ID_W   = 11;
    localparam int CFG_W  = 11;
    localparam int SLOT_W = 10;
    localparam int ST_W   = 2;

    // Parent code that marks a root.
    localparam logic [PAR_W-1:0] ROOT_CODE = '1;

    localparam logic [CFG_W-1:0] MAX_NODES_RESET = CFG_W'(NODES);

    // Operation codes.
    localparam logic OP_CREATE  = 1'b0;
    localparam logic OP_DESTROY = 1'b1;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_CREATED   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_DESTROYED = 2'd2;
    localparam logic [ST_W-1:0] ST_IGNORED   = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_FIN
    } t_state;

    // Command broadcast to every cell.
    typedef struct packed {
        logic             wr_en;
        logic [NW-1:0]    wr_id;
        logic [PAR_W-1:0] wr_parent;
        logic [NW-1:0]    scan_id;
        logic             commit;
        logic             live;
    } t_cell_cmd;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic             valid;
        logic             live;
        logic [CNT_W-1:0] count;
    } t_token;

endpackage

`default_nettype wire

// File: rtl/nsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module nsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/nsa_cell.sv
// One slot cell: holds the alive flag and parent of its slot, and takes part
// in the destroy scan. Depends on nsa_pkg.
`default_nettype none

module nsa_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [nsa_pkg::NW-1:0] i_index,
    input  nsa_pkg::t_cell_cmd     i_cmd,
    input  nsa_pkg::t_token        i_tok,
    output nsa_pkg::t_token        o_tok
);

    logic                      r_alive;
    logic                      r_pending;
    logic [nsa_pkg::PAR_W-1:0] r_parent;
    nsa_pkg::t_token           r_tok;

    logic                      n_alive;
    logic                      n_pending;
    logic [nsa_pkg::PAR_W-1:0] n_parent;
    nsa_pkg::t_token           n_tok;

    logic sel_scan;
    logic sel_wr;
    logic cand;
    logic hit;

    // Scan step and slot update. A child found during the scan is only
    // marked pending; it is turned into a root at commit if the target was alive.
    always_comb begin
        sel_scan = (i_index == i_cmd.scan_id);
        sel_wr   = (i_index == i_cmd.wr_id);
        cand     = i_tok.valid && r_alive && !sel_scan &&
                   (r_parent == nsa_pkg::PAR_W'(i_cmd.scan_id));
        hit      = i_tok.valid && r_alive && sel_scan;

        n_tok.valid = i_tok.valid;
        n_tok.live  = i_tok.live | hit;
        n_tok.count = i_tok.count + nsa_pkg::CNT_W'(cand);

        n_alive   = r_alive;
        n_parent  = r_parent;
        n_pending = r_pending | cand;

        if (i_cmd.commit) begin
            n_pending = 1'b0;
            if (i_cmd.live) begin
                if (r_pending) begin
                    n_parent = nsa_pkg::ROOT_CODE;
                end
                if (sel_scan) begin
                    n_alive  = 1'b0;
                    n_parent = nsa_pkg::ROOT_CODE;
                end
            end
        end else if (i_cmd.wr_en && sel_wr) begin
            n_alive  = 1'b1;
            n_parent = i_cmd.wr_parent;
        end
    end

    // Control state of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive   <= 1'b0;
            r_pending <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_alive   <= n_alive;
            r_pending <= n_pending;
            r_tok     <= n_tok;
        end
    end

    // Parent store needs no reset: it is only read while the slot is alive.
    always_ff @(posedge i_clk) begin
        r_parent <= n_parent;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/nsa_chain.sv
// Row of slot cells through which the destroy scan token travels, one cell
// per cycle. Depends on nsa_pkg and nsa_cell.
`default_nettype none

module nsa_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  nsa_pkg::t_cell_cmd i_cmd,
    output nsa_pkg::t_token    o_tok
);

    nsa_pkg::t_token tok [nsa_pkg::NODES+1];

    // A fresh token enters the first cell with nothing found yet.
    assign tok[0] = '{valid: i_start, live: 1'b0, count: '0};

    for (genvar g = 0; g < nsa_pkg::NODES; g++) begin : g_cell
        nsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (nsa_pkg::NW'(g)),
            .i_cmd   (i_cmd),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    assign o_tok = tok[nsa_pkg::NODES];

endmodule

`default_nettype wire

// File: rtl/node_slot_allocator.sv
// Top level of the slot allocator: controller, free stack RAM and the row of
// slot cells. Depends on nsa_pkg, nsa_ram, nsa_chain and assert_macros.svh.
//
// One request at a time. A create that reuses a released slot passes through S_POP,
// which waits on the registered free stack RAM read, and then S_FIN; a create of
// a fresh slot or a full-pool answer goes from idle straight to S_FIN. A destroy
// of a slot in range walks a token through all NODES cells, one cell per cycle,
// then commits in S_SCAN and passes through S_FIN; an out of range destroy
// behaves like a fresh create. A stalled output adds its stall only when a second
// result is ready while the first still waits.
// The next request is accepted while the previous result waits on the output.
// max_nodes is written through its own port and must only be changed while idle.
`default_nettype none
`include "assert_macros.svh"

module node_slot_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic signed [nsa_pkg::PAR_W-1:0] i_parent_id,
    input  logic signed [nsa_pkg::ID_W-1:0]  i_node_id,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nsa_pkg::ST_W-1:0]      o_status,
    output logic [nsa_pkg::SLOT_W-1:0]    o_slot,
    output logic [nsa_pkg::SLOT_W-1:0]    o_orphaned,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nsa_pkg::CFG_W-1:0]     i_cfg_data
);

    nsa_pkg::t_state r_state, n_state;

    logic [nsa_pkg::HW-1:0]    r_free_depth, n_free_depth;
    logic [nsa_pkg::HW-1:0]    r_high_water, n_high_water;
    logic [nsa_pkg::CFG_W-1:0] r_max_nodes;
    logic                      r_inject, n_inject;
    logic                      r_out_valid, n_out_valid;

    logic [nsa_pkg::NW-1:0]    r_id, n_id;
    logic [nsa_pkg::PAR_W-1:0] r_parent, n_parent;
    logic [nsa_pkg::ST_W-1:0]  r_res_status, n_res_status;
    logic [nsa_pkg::NW-1:0]    r_res_slot, n_res_slot;
    logic [nsa_pkg::CNT_W-1:0] r_res_orph, n_res_orph;
    logic [nsa_pkg::ST_W-1:0]  r_out_status, n_out_status;
    logic [nsa_pkg::NW-1:0]    r_out_slot, n_out_slot;
    logic [nsa_pkg::CNT_W-1:0] r_out_orph, n_out_orph;

    nsa_pkg::t_cell_cmd        cmd;
    nsa_pkg::t_token           exit_tok;
    logic                      in_acc;
    logic                      ram_we;
    logic [nsa_pkg::NW-1:0]    ram_waddr;
    logic [nsa_pkg::NW-1:0]    ram_raddr;
    logic [nsa_pkg::NW-1:0]    ram_rdata;
    logic                      pool_full;
    logic                      node_bad;

    // Free stack of released slots.
    nsa_ram #(
        .WIDTH (nsa_pkg::NW),
        .DEPTH (nsa_pkg::NODES)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_id),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Row of slot cells.
    nsa_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_inject),
        .i_cmd   (cmd),
        .o_tok   (exit_tok)
    );

    assign o_in_ready  = (r_state == nsa_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign ram_raddr   = r_free_depth[nsa_pkg::NW-1:0] - nsa_pkg::NW'(1);
    assign ram_waddr   = r_free_depth[nsa_pkg::NW-1:0];
    assign pool_full   = (r_high_water >= nsa_pkg::HW'(r_max_nodes)) ||
                         (r_high_water >= nsa_pkg::HW'(nsa_pkg::NODES));
    assign node_bad    = i_node_id[nsa_pkg::ID_W-1] ||
                         (nsa_pkg::HW'($unsigned(i_node_id)) >= r_high_water);

    // Next state, cell commands and result bookkeeping.
    always_comb begin
        n_state      = r_state;
        n_free_depth = r_free_depth;
        n_high_water = r_high_water;
        n_inject     = 1'b0;
        n_out_valid  = r_out_valid;
        n_id         = r_id;
        n_parent     = r_parent;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_orph   = r_res_orph;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_orph   = r_out_orph;
        ram_we       = 1'b0;

        cmd.wr_en     = 1'b0;
        cmd.wr_id     = r_high_water[nsa_pkg::NW-1:0];
        cmd.wr_parent = i_parent_id;
        cmd.scan_id   = r_id;
        cmd.commit    = 1'b0;
        cmd.live      = exit_tok.live;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            nsa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_parent   = i_parent_id;
                    n_res_orph = '0;
                    n_res_slot = '0;
                    n_state    = nsa_pkg::S_FIN;
                    if (i_op == nsa_pkg::OP_CREATE) begin
                        if (r_free_depth != '0) begin
                            // Reuse the last released slot.
                            n_free_depth = r_free_depth - nsa_pkg::HW'(1);
                            n_state      = nsa_pkg::S_POP;
                        end else if (pool_full) begin
                            n_res_status = nsa_pkg::ST_FULL;
                        end else begin
                            // Hand out a never-used slot.
                            cmd.wr_en    = 1'b1;
                            n_high_water = r_high_water + nsa_pkg::HW'(1);
                            n_res_status = nsa_pkg::ST_CREATED;
                            n_res_slot   = r_high_water[nsa_pkg::NW-1:0];
                        end
                    end else begin
                        if (node_bad) begin
                            n_res_status = nsa_pkg::ST_IGNORED;
                        end else begin
                            n_id     = i_node_id[nsa_pkg::NW-1:0];
                            n_inject = 1'b1;
                            n_state  = nsa_pkg::S_SCAN;
                        end
                    end
                end
            end
            nsa_pkg::S_POP: begin
                cmd.wr_en     = 1'b1;
                cmd.wr_id     = ram_rdata;
                cmd.wr_parent = r_parent;
                n_res_status  = nsa_pkg::ST_CREATED;
                n_res_slot    = ram_rdata;
                n_state       = nsa_pkg::S_FIN;
            end
            nsa_pkg::S_SCAN: begin
                // The token has left the last cell: commit, and push the slot if it was alive.
                if (exit_tok.valid) begin
                    cmd.commit = 1'b1;
                    n_state    = nsa_pkg::S_FIN;
                    if (exit_tok.live) begin
                        ram_we       = 1'b1;
                        n_free_depth = r_free_depth + nsa_pkg::HW'(1);
                        n_res_status = nsa_pkg::ST_DESTROYED;
                        n_res_slot   = r_id;
                        n_res_orph   = exit_tok.count;
                    end else begin
                        n_res_status = nsa_pkg::ST_IGNORED;
                    end
                end
            end
            nsa_pkg::S_FIN: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_orph   = r_res_orph;
                    n_state      = nsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nsa_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_depth <= '0;
            r_high_water <= '0;
            r_max_nodes  <= nsa_pkg::MAX_NODES_RESET;
            r_inject     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_free_depth <= n_free_depth;
            r_high_water <= n_high_water;
            r_inject     <= n_inject;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_nodes <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_parent     <= n_parent;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_orph   <= n_res_orph;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_orph   <= n_out_orph;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot      = nsa_pkg::SLOT_W'(r_out_slot);
    assign o_orphaned  = nsa_pkg::SLOT_W'(r_out_orph);

    // Every released slot was once handed out.
    `NSA_ASSERT(a_depth_le_hw, i_clk, i_rst_n, r_free_depth <= r_high_water, "free stack deeper than handed-out slots")
    // Slots handed out never exceed the pool size.
    `NSA_ASSERT(a_hw_le_nodes, i_clk, i_rst_n, r_high_water <= nsa_pkg::HW'(nsa_pkg::NODES), "high-water count beyond pool size")
    // The scan token only leaves the row while the controller waits for it.
    `NSA_ASSERT(a_exit_in_scan, i_clk, i_rst_n, exit_tok.valid |-> r_state == nsa_pkg::S_SCAN, "scan token left the row outside a destroy")
    // A scan is started only from a destroy accepted in idle.
    `NSA_ASSERT(a_inject_src, i_clk, i_rst_n, r_inject |-> $past(in_acc) && r_state == nsa_pkg::S_SCAN, "scan started without a destroy request")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench of node_slot_allocator: create and destroy requests go in through
// paced bursts; each result is checked against the directed table or an in-bench
// pool predictor. Depends on nsa_pkg and on the RTL of the slot allocator.

module tb;

    typedef struct packed {
        logic [nsa_pkg::ST_W-1:0]   status;
        logic [nsa_pkg::SLOT_W-1:0] slot;
        logic [nsa_pkg::SLOT_W-1:0] orphaned;
    } t_pool_result;

    // One directed request; the expected result is only used where typed is set.
    typedef struct packed {
        logic                      op;
        logic [nsa_pkg::PAR_W-1:0] parent;
        logic [nsa_pkg::ID_W-1:0]  node;
        logic                      typed;
        t_pool_result              want;
    } t_stim_row;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } t_ready_mode;

    localparam int N_DIRECTED  = 23;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 80;
    localparam int SCAN_CYCLES = nsa_pkg::NODES + 8;
    localparam logic [nsa_pkg::ID_W-1:0] MOST_NEG = 11'h400;

    // Pool limits written before each random phase, extremes included.
    localparam logic [nsa_pkg::CFG_W-1:0] PHASE_LIMITS [N_PHASES] = '{
        11'd0, 11'd2047, 11'd1, 11'd9, 11'd1024, 11'd16, 11'd3
    };

    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // Nothing handed out yet, so every destroy is ignored.
        '{nsa_pkg::OP_DESTROY, nsa_pkg::ROOT_CODE, 11'd0,
          1'b1, '{nsa_pkg::ST_IGNORED, 10'd0, 10'd0}},
        '{nsa_pkg::OP_DESTROY, 11'd0, nsa_pkg::ROOT_CODE,
          1'b1, '{nsa_pkg::ST_IGNORED, 10'd0, 10'd0}},
        // Fresh slots in order; parents are stored unchecked, slot 5 is its own parent.
        '{nsa_pkg::OP_CREATE, nsa_pkg::ROOT_CODE, 11'h3ff,
          1'b1, '{nsa_pkg::ST_CREATED, 10'd0, 10'd0}},
        '{nsa_pkg::OP_CREATE, 11'd0, MOST_NEG,
          1'b1, '{nsa_pkg::ST_CREATED, 10'd1, 10'd0}},
        '{nsa_pkg::OP_CREATE, 11'd0, 11'd0,
          1'b1, '{nsa_pkg::ST_CREATED, 10'd2, 10'd0}},
        '{nsa_pkg::OP_CREATE, 11'h3ff, 11'd0,
          1'b1, '{nsa_pkg::ST_CREATED, 10'd3, 10'd0}},
        '{nsa_pkg::OP_CREATE, MOST_NEG, 11'd0,
          1'b1, '{nsa_pkg::ST_CREATED, 10'd4, 10'd0}},
        '{nsa_pkg::OP_CREATE, 11'd5, 11'd0,
          1'b1, '{nsa_pkg::ST_CREATED, 10'd5, 10'd0}},
        '{nsa_pkg::OP_CREATE, 11'd1, 11'd0,
          1'b1, '{nsa_pkg::ST_CREATED, 10'd6, 10'd0}},
        // Out of range destroys: top, most negative, and just at the high-water mark.
        '{nsa_pkg::OP_DESTROY, 11'd0, 11'h3ff,
          1'b1, '{nsa_pkg::ST_IGNORED, 10'd0, 10'd0}},
        '{nsa_pkg::OP_DESTROY, 11'h3ff, MOST_NEG,
          1'b1, '{nsa_pkg::ST_IGNORED, 10'd0, 10'd0}},
        '{nsa_pkg::OP_DESTROY, 11'd0, 11'd7,
          1'b1, '{nsa_pkg::ST_IGNORED, 10'd0, 10'd0}},
        // Orphan two children, then a dead slot, then the self-parented slot, then slot 1 with its one child.
        '{nsa_pkg::OP_DESTROY, 11'd0, 11'd0,
          1'b1, '{nsa_pkg::ST_DESTROYED, 10'd0, 10'd2}},
        '{nsa_pkg::OP_DESTROY, 11'd0, 11'd0,
          1'b1, '{nsa_pkg::ST_IGNORED, 10'd0, 10'd0}},
        '{nsa_pkg::OP_DESTROY, 11'd0, 11'd5,
          1'b1, '{nsa_pkg::ST_DESTROYED, 10'd5, 10'd0}},
        '{nsa_pkg::OP_DESTROY, 11'd0, 11'd1,
          1'b1, '{nsa_pkg::ST_DESTROYED, 10'd1, 10'd1}},
        // Reuse from the free stack in LIFO order, then a fresh slot again, then three destroys.
        '{nsa_pkg::OP_CREATE,  11'd2,              11'd0, 1'b0, '0},
        '{nsa_pkg::OP_CREATE,  nsa_pkg::ROOT_CODE, 11'd0, 1'b0, '0},
        '{nsa_pkg::OP_CREATE,  11'd3,              11'd0, 1'b0, '0},
        '{nsa_pkg::OP_CREATE,  11'd0,              11'd0, 1'b0, '0},
        '{nsa_pkg::OP_DESTROY, 11'd0,              11'd2, 1'b0, '0},
        '{nsa_pkg::OP_DESTROY, 11'd0,              11'd6, 1'b0, '0},
        '{nsa_pkg::OP_DESTROY, 11'd0,              11'd3, 1'b0, '0}
    };

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             i_op        = nsa_pkg::OP_CREATE;
    logic signed [nsa_pkg::PAR_W-1:0] i_parent_id = '0;
    logic signed [nsa_pkg::ID_W-1:0]  i_node_id   = '0;
    logic                             i_out_ready = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic [nsa_pkg::CFG_W-1:0]        i_cfg_data  = '0;
    logic                             o_in_ready;
    logic                             o_out_valid;
    logic [nsa_pkg::ST_W-1:0]         o_status;
    logic [nsa_pkg::SLOT_W-1:0]       o_slot;
    logic [nsa_pkg::SLOT_W-1:0]       o_orphaned;
    logic                             o_cfg_ready;

    // Predicted pool state.
    logic                      slot_alive [nsa_pkg::NODES];
    logic [nsa_pkg::PAR_W-1:0] slot_parent [nsa_pkg::NODES];
    logic [nsa_pkg::NW-1:0]    released_stack [nsa_pkg::NODES];
    int                        released_depth  = 0;
    int                        high_water_mark = 0;
    int                        pool_limit      = nsa_pkg::NODES;

    t_pool_result pending_results [$];
    int           errors = 0;
    int           burst_left = 0;
    int           n_created = 0, n_full = 0, n_destroyed = 0, n_ignored = 0;
    int           n_orphaned = 0, most_orphaned = 0;
    t_ready_mode  ready_mode = READY_ALWAYS;
    int           ready_left = 0;

    node_slot_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_parent_id (i_parent_id),
        .i_node_id   (i_node_id),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_orphaned  (o_orphaned),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Work out the result of one request and advance the predicted pool.
    function automatic t_pool_result predict_pool(input logic op,
                                                  input logic [nsa_pkg::PAR_W-1:0] parent,
                                                  input logic [nsa_pkg::ID_W-1:0] node);
        t_pool_result res;
        int lim;
        int id;
        int kids;
        int i;
        res  = '0;
        lim  = (pool_limit < nsa_pkg::NODES) ? pool_limit : nsa_pkg::NODES;
        kids = 0;
        if (op == nsa_pkg::OP_CREATE) begin
            if (released_depth > 0) begin
                released_depth--;
                id = released_stack[released_depth];
            end else if (high_water_mark >= lim) begin
                res.status = nsa_pkg::ST_FULL;
                n_full++;
                return res;
            end else begin
                id = high_water_mark;
                high_water_mark++;
            end
            slot_alive[id]  = 1'b1;
            slot_parent[id] = parent;
            res.status = nsa_pkg::ST_CREATED;
            res.slot   = nsa_pkg::SLOT_W'(id);
            n_created++;
        end else if (node[nsa_pkg::ID_W-1] || int'(node) >= high_water_mark ||
                     !slot_alive[node[nsa_pkg::NW-1:0]]) begin
            res.status = nsa_pkg::ST_IGNORED;
            n_ignored++;
        end else begin
            id = node[nsa_pkg::NW-1:0];
            slot_alive[id]  = 1'b0;
            slot_parent[id] = nsa_pkg::ROOT_CODE;
            // Every live child of the released slot becomes a root.
            for (i = 0; i < high_water_mark; i++) begin
                if (slot_alive[i] && slot_parent[i] == nsa_pkg::PAR_W'(id)) begin
                    slot_parent[i] = nsa_pkg::ROOT_CODE;
                    kids++;
                end
            end
            released_stack[released_depth] = nsa_pkg::NW'(id);
            released_depth++;
            res.status   = nsa_pkg::ST_DESTROYED;
            res.slot     = nsa_pkg::SLOT_W'(id);
            res.orphaned = nsa_pkg::SLOT_W'(kids);
            n_destroyed++;
            n_orphaned += kids;
            if (kids > most_orphaned) most_orphaned = kids;
        end
        return res;
    endfunction

    // A live slot, either the lowest one or one found from a random start; -1 if none.
    function automatic int pick_alive(input bit lowest);
        int start;
        int i;
        if (high_water_mark == 0) return -1;
        start = lowest ? 0 : $urandom_range(0, high_water_mark - 1);
        for (i = 0; i < high_water_mark; i++) begin
            if (slot_alive[(start + i) % high_water_mark]) return (start + i) % high_water_mark;
        end
        return -1;
    endfunction

    // Hold a request until it is taken, then queue what it should produce.
    task automatic send_request(input logic op, input logic [nsa_pkg::PAR_W-1:0] parent,
                                input logic [nsa_pkg::ID_W-1:0] node, input logic typed,
                                input t_pool_result want);
        t_pool_result predicted;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_parent_id <= parent;
        i_node_id   <= node;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_pool(op, parent, node);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // The sender runs in bursts; between bursts it idles, now and then for up to a whole scan.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(7, SCAN_CYCLES)
                                               : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [nsa_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pool_limit = int'(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The receiver switches between always ready, random stalls and long stalls.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 2));
            ready_left <= $urandom_range(20, 300);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_RANDOM: i_out_ready <= ($urandom_range(0, 2) != 0);
            default:      i_out_ready <= (ready_left % 8 == 0);
        endcase
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_pool_result got;
        t_pool_result oldest;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_slot, o_orphaned};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d slot %0d orphaned %0d",
                         $time, got.status, got.slot, got.orphaned);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                if (got.status !== oldest.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, oldest.status, got.status);
                    errors++;
                end
                if (got.slot !== oldest.slot) begin
                    $display("%0t: slot mismatch: expected %0d, got %0d",
                             $time, oldest.slot, got.slot);
                    errors++;
                end
                if (got.orphaned !== oldest.orphaned) begin
                    $display("%0t: orphaned mismatch: expected %0d, got %0d",
                             $time, oldest.orphaned, got.orphaned);
                    errors++;
                end
            end
        end
    end

    initial begin
        foreach (slot_alive[i]) slot_alive[i] = 1'b0;
    end

    // Stimulus: reset, the directed table, then random phases under several pool limits.
    initial begin : stimulus
        int                        phase;
        int                        k;
        int                        pick;
        int                        roll;
        logic                      op;
        logic [nsa_pkg::PAR_W-1:0] par;
        logic [nsa_pkg::ID_W-1:0]  node;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            pace_sender();
            send_request(DIRECTED[r].op, DIRECTED[r].parent, DIRECTED[r].node,
                         DIRECTED[r].typed, DIRECTED[r].want);
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            wait_idle();
            write_limit(PHASE_LIMITS[phase]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pace_sender();
                pick = pick_alive($urandom_range(0, 3) == 0);
                op   = ($urandom_range(0, 99) < 55) ? nsa_pkg::OP_CREATE : nsa_pkg::OP_DESTROY;
                // Parents are mostly live slots, so destroys have children to orphan.
                roll = $urandom_range(0, 19);
                if (roll < 3)
                    par = nsa_pkg::PAR_W'($urandom_range(0, 2047));
                else if (roll < 7 || pick < 0)
                    par = nsa_pkg::ROOT_CODE;
                else
                    par = nsa_pkg::PAR_W'(pick);
                // Destroys mostly hit live slots; the rest are dead, out of range or noise.
                roll = $urandom_range(0, 19);
                if (roll < 3)
                    node = nsa_pkg::ID_W'($urandom_range(0, 2047));
                else if (roll < 6 || pick < 0)
                    node = nsa_pkg::ID_W'($urandom_range(0, high_water_mark + 1));
                else
                    node = nsa_pkg::ID_W'(pick);
                send_request(op, par, node, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SCAN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d creates, %0d pool-full refusals, %0d destroys, %0d ignored",
                 n_created, n_full, n_destroyed, n_ignored);
        $display("over %0d pool limits; %0d children orphaned, at most %0d by one destroy",
                 N_PHASES + 1, n_orphaned, most_orphaned);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// File: node_slot_allocator.f
+incdir+rtl
rtl/nsa_pkg.sv
rtl/nsa_ram.sv
rtl/nsa_cell.sv
rtl/nsa_chain.sv
rtl/node_slot_allocator.sv
tb/tb.sv
